// ===== design/tlis_pkg.sv =====
// shared types and constants of the linear interpolating table sampler
// no dependencies; imported by every module of the block
`default_nettype none

package tlis_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int POS_W    = 32;
  localparam int INT_W    = POS_W - FRAC_W;
  localparam int LEN_W    = 11;
  localparam int INDEX_W  = 10;

  // stream packing
  localparam int IN_FIELDS_W  = INDEX_W + SAMPLE_W + POS_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

  // table depth default
  localparam int TBL_DEPTH_DEFAULT = 1024;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = LEN_W;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LENGTH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_MODE    = 1'b1;
  localparam logic [LEN_W-1:0]       TABLE_LENGTH_RST = LEN_W'(1024);

  // item kinds
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [INDEX_W-1:0]         idx;
    logic [SAMPLE_W-1:0]        value;
    logic [POS_W-1:0]           pos;
    logic                       last;
  } item_t;

  // table access request: write or two-neighbour read
  typedef struct packed {
    logic                       op;
    logic                       zero;
    logic [INDEX_W-1:0]         idx;
    logic [SAMPLE_W-1:0]        value;
    logic [LEN_W-1:0]           lo;
    logic [LEN_W-1:0]           hi;
    logic [FRAC_W-1:0]          frac;
    logic                       last;
  } access_t;

endpackage

`default_nettype wire

// ===== design/tlis_mod_pipe.sv =====
// pipelined restoring remainder of the integer position magnitude by the table length
// depends on tlis_pkg
`default_nettype none

module tlis_mod_pipe
  import tlis_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [LEN_W-1:0] len,
  input  wire logic             in_valid,
  input  wire item_t            in_item,
  output logic                  out_valid,
  output item_t                 out_item,
  output logic [LEN_W-1:0]      out_rem
);

  logic [INT_W-1:0] int_part;
  logic [INT_W-1:0] in_mag;

  assign int_part = in_item.pos[POS_W-1:FRAC_W];
  assign in_mag   = in_item.pos[POS_W-1] ? (~int_part + INT_W'(1)) : int_part;

  logic             st_valid [INT_W];
  item_t            st_item  [INT_W];
  logic [INT_W-1:0] st_mag   [INT_W];
  logic [LEN_W-1:0] st_rem   [INT_W];

  for (genvar k = 0; k < INT_W; k++) begin : g_stage
    logic             prev_valid;
    item_t            prev_item;
    logic [INT_W-1:0] prev_mag;
    logic [LEN_W-1:0] prev_rem;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   reduced;

    if (k == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev_item  = in_item;
      assign prev_mag   = in_mag;
      assign prev_rem   = '0;
    end else begin : g_next
      assign prev_valid = st_valid[k-1];
      assign prev_item  = st_item[k-1];
      assign prev_mag   = st_mag[k-1];
      assign prev_rem   = st_rem[k-1];
    end

    // one dividend bit per stage, msb first
    assign trial   = {prev_rem, prev_mag[INT_W-1-k]};
    assign reduced = trial - {1'b0, len};

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (en) begin
        st_valid[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_item[k] <= prev_item;
        st_mag[k]  <= prev_mag;
        st_rem[k]  <= (trial >= {1'b0, len}) ? reduced[LEN_W-1:0] : trial[LEN_W-1:0];
      end
    end
  end

  assign out_valid = st_valid[INT_W-1];
  assign out_item  = st_item[INT_W-1];
  assign out_rem   = st_rem[INT_W-1];

endmodule

`default_nettype wire

// ===== design/tlis_table.sv =====
// sample memory with two read ports, difference multiply and saturating add
// depends on tlis_pkg
`default_nettype none

module tlis_table
  import tlis_pkg::*;
#(
  parameter int TABLE_DEPTH = TBL_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire access_t       in_req,
  output logic               out_valid,
  output logic [SAMPLE_W-1:0] out_value,
  output logic               out_last
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int PROD_W = FRAC_W + SAMPLE_W + 2;
  localparam int SUM_W  = SAMPLE_W + 2;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {3'b000, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {3'b111, {(SAMPLE_W-1){1'b0}}};

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];

  logic wr;
  assign wr = in_valid && (in_req.op == OP_WRITE) && (32'(in_req.idx) < TABLE_DEPTH);

  // memory stage
  logic                m_valid;
  logic                m_zero;
  logic                m_last;
  logic [FRAC_W-1:0]   m_frac;
  logic [SAMPLE_W-1:0] rd_a;
  logic [SAMPLE_W-1:0] rd_b;

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr) begin
        mem[AW'(in_req.idx)] <= in_req.value;
      end
      rd_a <= mem[AW'(in_req.lo)];
      rd_b <= mem[AW'(in_req.hi)];
      m_zero <= in_req.zero;
      m_last <= in_req.last;
      m_frac <= in_req.frac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= in_valid && (in_req.op == OP_SAMPLE);
    end
  end

  // product stage
  logic signed [FRAC_W:0]     frac_s;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic                       p_valid;
  logic                       p_zero;
  logic                       p_last;
  logic signed [SAMPLE_W-1:0] p_a;
  logic signed [PROD_W-1:0]   p_prod;

  // both operands sign extended to the product width before the multiply
  assign frac_s = $signed({1'b0, m_frac});
  assign diff   = $signed({rd_b[SAMPLE_W-1], rd_b}) - $signed({rd_a[SAMPLE_W-1], rd_a});
  assign prod   = PROD_W'(frac_s) * PROD_W'(diff);

  always_ff @(posedge clk) begin
    if (en) begin
      p_zero <= m_zero;
      p_last <= m_last;
      p_a    <= $signed(rd_a);
      p_prod <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= m_valid;
    end
  end

  // floor of product, add, saturate
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0]  sum;
  logic [SAMPLE_W-1:0]      sat;

  assign shifted = p_prod >>> FRAC_W;
  assign sum     = $signed({{2{p_a[SAMPLE_W-1]}}, p_a}) + $signed(shifted[SUM_W-1:0]);

  always_comb begin
    if (sum > SUM_MAX) begin
      sat = SUM_MAX[SAMPLE_W-1:0];
    end else if (sum < SUM_MIN) begin
      sat = SUM_MIN[SAMPLE_W-1:0];
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  assign out_valid = p_valid;
  assign out_value = p_zero ? '0 : sat;
  assign out_last  = p_last;

endmodule

`default_nettype wire

// ===== design/table_linear_interp_sampler_unit.sv =====
// top level of the linear interpolating table sampler: stream ports, config registers,
// neighbour address stage and output skid; depends on tlis_pkg, tlis_mod_pipe, tlis_table
`default_nettype none

// One item is taken per clock on the input stream while ready is high and, for
// sample items, one result leaves per clock on the output stream while the receiver
// is ready. A write item (tuser low) stores entry_value at entry_index and yields
// nothing; a sample item (tuser high) reads the two table entries around its Q15.16
// position and returns a + frac*(b-a), with the product floored. Clamp mode limits
// the position to the table ends, repeat mode folds it into the table period. Items
// pass the 16-stage restoring remainder pipeline that folds the position by the
// table length, then the address, memory read and multiply stages. Writes pass
// through the same pipeline, so reads and writes hit the table in arrival order. An
// output register with a skid stage behind it lets the input keep flowing while a
// result waits; ready drops only when the skid stage is occupied. Entries must be
// written before they are sampled. The user must make configuration writes only
// while no item is in flight; the block does not enforce this.
module table_linear_interp_sampler_unit
  import tlis_pkg::*;
#(
  parameter int TABLE_DEPTH = TBL_DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // entry_index [9:0], entry_value [25:10], position [57:26], zero fill above
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  wire logic                   s_axis_tuser,
  // batch_end
  input  wire logic                   s_axis_tlast,
  // output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // sample_value [15:0]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // batch_last
  output logic                        m_axis_tlast
);

  // configuration registers
  logic [LEN_W-1:0] table_length;
  logic             wrap_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= TABLE_LENGTH_RST;
      wrap_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_LENGTH: table_length <= cfg_data;
        REG_WRAP_MODE:    wrap_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // length in use never exceeds the table depth
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] last_entry;

  assign len_eff    = (32'(table_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH) : table_length;
  assign last_entry = len_eff - LEN_W'(1);

  // whole pipeline advances unless the skid stage holds a result
  logic skid_valid;
  logic en;

  assign en            = !skid_valid;
  assign s_axis_tready = en;

  // input register
  logic  s0_valid;
  item_t s0_item;
  item_t in_item;

  assign in_item.op    = s_axis_tuser;
  assign in_item.idx   = s_axis_tdata[INDEX_W-1:0];
  assign in_item.value = s_axis_tdata[INDEX_W+SAMPLE_W-1:INDEX_W];
  assign in_item.pos   = s_axis_tdata[IN_FIELDS_W-1:INDEX_W+SAMPLE_W];
  assign in_item.last  = s_axis_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item <= in_item;
    end
  end

  // position folding by the table length
  logic             mp_valid;
  item_t            mp_item;
  logic [LEN_W-1:0] mp_rem;

  tlis_mod_pipe u_mod_pipe (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .len       (len_eff),
    .in_valid  (s0_valid),
    .in_item   (s0_item),
    .out_valid (mp_valid),
    .out_item  (mp_item),
    .out_rem   (mp_rem)
  );

  // neighbour address stage
  access_t acc_next;
  access_t acc;
  logic    acc_valid;

  always_comb begin
    logic [INT_W-1:0] int_part;
    logic             neg;
    logic [LEN_W-1:0] folded;

    int_part = mp_item.pos[POS_W-1:FRAC_W];
    neg      = mp_item.pos[POS_W-1];

    acc_next.op    = mp_item.op;
    acc_next.zero  = (len_eff == '0);
    acc_next.idx   = mp_item.idx;
    acc_next.value = mp_item.value;
    acc_next.last  = mp_item.last;
    folded         = (neg && (mp_rem != '0)) ? (len_eff - mp_rem) : mp_rem;

    if (wrap_mode) begin
      // repeat: upper neighbour of the last entry wraps to entry zero
      acc_next.lo   = folded;
      acc_next.hi   = (folded < last_entry) ? (folded + LEN_W'(1)) : '0;
      acc_next.frac = mp_item.pos[FRAC_W-1:0];
    end else begin
      // clamp to the table ends
      if (neg) begin
        acc_next.lo   = '0;
        acc_next.frac = '0;
      end else if (32'(int_part) >= 32'(last_entry)) begin
        acc_next.lo   = last_entry;
        acc_next.frac = '0;
      end else begin
        acc_next.lo   = LEN_W'(int_part);
        acc_next.frac = mp_item.pos[FRAC_W-1:0];
      end
      acc_next.hi = (acc_next.lo < last_entry) ? (acc_next.lo + LEN_W'(1)) : last_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (en) begin
      acc_valid <= mp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= acc_next;
    end
  end

  // table access and interpolation
  logic                fin_valid;
  logic [SAMPLE_W-1:0] fin_value;
  logic                fin_last;

  tlis_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (acc_valid),
    .in_req    (acc),
    .out_valid (fin_valid),
    .out_value (fin_value),
    .out_last  (fin_last)
  );

  // output register and skid stage
  logic                out_valid;
  logic [SAMPLE_W-1:0] out_value;
  logic                out_last;
  logic [SAMPLE_W-1:0] skid_value;
  logic                skid_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (fin_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        out_value <= skid_value;
        out_last  <= skid_last;
      end
    end else if (fin_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_value <= fin_value;
        out_last  <= fin_last;
      end else begin
        skid_value <= fin_value;
        skid_last  <= fin_last;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_value);
  assign m_axis_tlast  = out_last;

  // skid stage only fills behind a held output
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full while output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_axis_tready |=> skid_valid)
    else $error("skid stage dropped a result that was not taken");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_axis_tready && fin_valid))
    else $error("skid stage filled without a stalled output");

endmodule

`default_nettype wire
